>>> hdl/v3n_pkg.sv
`timescale 1ns / 1ps
package v3n_pkg;
	localparam int RegWidth = 15;
	localparam int AddrWidth = 3;
	localparam logic [AddrWidth-1:0] AddrSingularLimit = 3'd0;
	localparam logic [AddrWidth-1:0] AddrUnitTolerance = 3'd4;
	localparam logic [RegWidth-1:0] SingularLimitReset = 15'd1;
	localparam logic [RegWidth-1:0] UnitToleranceReset = 15'd4;
endpackage

>>> hdl/v3n_sqrt_cell.sv
`timescale 1ns / 1ps
// One trial-squaring step of the square root: settles one result bit per cycle when not stalled.
module v3n_sqrt_cell #(
	parameter int SumWidth = 34,
	parameter int RootWidth = 17,
	parameter int Step = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  logic                 stall,
	input  logic [SumWidth-1:0]  rem_in,
	input  logic [RootWidth-1:0] root_in,
	output logic                 valid_out,
	output logic [SumWidth-1:0]  rem_out,
	output logic [RootWidth-1:0] root_out
);
	localparam int Bit = RootWidth - 1 - Step;
	logic [RootWidth-1:0] trial;
	logic [SumWidth+1:0] sq;
	always_comb begin
		trial = root_in | (RootWidth'(1) << Bit);
		sq = (SumWidth+2)'(trial) * (SumWidth+2)'(trial);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (!stall) begin
			valid_out <= valid_in;
		end
	end
	always_ff @(posedge clk) begin
		if (!stall) begin
			rem_out <= rem_in;
			root_out <= (sq <= (SumWidth+2)'(rem_in)) ? trial : root_in;
		end
	end
endmodule

>>> hdl/v3n_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step for three numerators sharing one divisor.
module v3n_div_cell #(
	parameter int NumWidth = 32,
	parameter int DenWidth = 17,
	parameter int Step = 0
) (
	input  logic                clk,
	input  logic                stall,
	input  logic [DenWidth-1:0] den,
	input  logic [NumWidth-1:0] num_in [3],
	input  logic [DenWidth:0]   rem_in [3],
	input  logic [NumWidth-1:0] quo_in [3],
	output logic [DenWidth:0]   rem_out [3],
	output logic [NumWidth-1:0] quo_out [3]
);
	localparam int Bit = NumWidth - 1 - Step;
	logic [DenWidth+1:0] shifted [3];
	logic [2:0] take;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shifted[i] = {rem_in[i], num_in[i][Bit]};
			take[i] = shifted[i] >= (DenWidth+2)'(den);
		end
	end
	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int i = 0; i < 3; i++) begin
				rem_out[i] <= take[i] ? (DenWidth+1)'(shifted[i] - (DenWidth+2)'(den))
					: (DenWidth+1)'(shifted[i]);
				quo_out[i] <= quo_in[i] | (take[i] ? (NumWidth'(1) << Bit) : '0);
			end
		end
	end
endmodule

>>> hdl/vector3_normalize_top.sv
`timescale 1ns / 1ps
// Stages in order: squares, their sum, the root cells, the divider cells, the output register.
// Throughput: one item per cycle while the output is not stalled.
// The whole pipe advances together and holds when the output item is stalled.
// Reset clears all valid bits and loads singular_limit = 1, unit_tolerance = 4.
// Payload registers are not reset.
module vector3_normalize_top #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [v3n_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_x,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_y,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [COMPONENT_WIDTH-1:0] unit_x,
	output logic signed [COMPONENT_WIDTH-1:0] unit_y,
	output logic signed [COMPONENT_WIDTH-1:0] unit_z,
	output logic status,
	output logic was_unit
);
	import v3n_pkg::*;

	// Magnitudes fit in CW bits; the sum of three squares in 2*CW+2 bits, root in CW+1.
	localparam int CW = COMPONENT_WIDTH;
	localparam int SW = 2 * CW + 2;
	localparam int RW = CW + 1;
	localparam int NW = CW + FRACTION_BITS;
	localparam int NSQ = RW;
	localparam int NDIV = NW;
	localparam int NST = 2 + NSQ + NDIV;

	logic [RegWidth-1:0] singular_limit_q, unit_tolerance_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			singular_limit_q <= SingularLimitReset;
			unit_tolerance_q <= UnitToleranceReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				AddrSingularLimit: singular_limit_q <= pwdata[RegWidth-1:0];
				AddrUnitTolerance: unit_tolerance_q <= pwdata[RegWidth-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			AddrSingularLimit: prdata = 32'(singular_limit_q);
			AddrUnitTolerance: prdata = 32'(unit_tolerance_q);
			default: prdata = '0;
		endcase
	end

	// The entire pipe moves as one; an output stall freezes every stage, which
	// also keeps each stalled payload steady. Input is refused only on that stall.
	logic adv;
	assign adv = !out_stall || !out_valid;
	assign in_stall = !adv;

	// Item side data that rides alongside both chains, indexed by stage.
	logic [NST:0] v;
	logic [CW-1:0] raw [NST+1][3];
	logic [2:0] neg [NST+1];
	logic [CW-1:0] mag [NST+1][3];
	assign v[0] = in_valid;
	assign raw[0][0] = vec_x;
	assign raw[0][1] = vec_y;
	assign raw[0][2] = vec_z;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[0][i] = raw[0][i][CW-1];
			mag[0][i] = neg[0][i] ? CW'(-raw[0][i]) : raw[0][i];
		end
	end

	// Stage 1: squares; stage 2: their sum.
	logic [2*CW-1:0] sq_s1 [3];
	logic [SW-1:0] sum_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s1[i] <= mag[0][i] * mag[0][i];
			sum_s2 <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
		end
	end

	genvar s;
	for (s = 0; s < NST; s++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[s+1] <= 1'b0;
			else if (adv) v[s+1] <= v[s];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				raw[s+1] <= raw[s];
				neg[s+1] <= neg[s];
				mag[s+1] <= mag[s];
			end
		end
	end

	// Square root chain.
	logic [SW-1:0] srem [NSQ+1];
	logic [RW-1:0] sroot [NSQ+1];
	logic [NSQ:0] sv_unused;
	assign srem[0] = sum_s2;
	assign sroot[0] = '0;
	for (s = 0; s < NSQ; s++) begin : g_sqrt
		v3n_sqrt_cell #(.SumWidth(SW), .RootWidth(RW), .Step(s)) u_cell (
			.clk(clk), .arst_n(arst_n), .valid_in(1'b0), .stall(!adv),
			.rem_in(srem[s]), .root_in(sroot[s]),
			.valid_out(sv_unused[s]), .rem_out(srem[s+1]), .root_out(sroot[s+1]));
	end
	assign sv_unused[NSQ] = 1'b0;

	// Decisions taken on the norm as it leaves the root chain.
	localparam int DS = 2 + NSQ;
	logic [RW-1:0] norm;
	logic sing, unit_ok;
	logic [RW-1:0] dev;
	localparam logic [RW-1:0] One = RW'(1) << FRACTION_BITS;
	always_comb begin
		norm = sroot[NSQ];
		sing = norm <= RW'(singular_limit_q);
		dev = (norm >= One) ? norm - One : One - norm;
		unit_ok = dev <= RW'(unit_tolerance_q);
	end

	// Divider chain; the divisor and flags ride with each step.
	logic [RW-1:0] den [NDIV+1];
	logic [NDIV:0] sg, wu;
	logic [NW-1:0] num [NDIV+1][3];
	logic [RW:0] drem [NDIV+1][3];
	logic [NW-1:0] quo [NDIV+1][3];
	assign den[0] = sing ? RW'(1) : norm;
	assign sg[0] = sing;
	assign wu[0] = unit_ok && !sing;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[0][i] = NW'(mag[DS][i]) << FRACTION_BITS;
			drem[0][i] = '0;
			quo[0][i] = '0;
		end
	end
	for (s = 0; s < NDIV; s++) begin : g_div
		v3n_div_cell #(.NumWidth(NW), .DenWidth(RW), .Step(s)) u_cell (
			.clk(clk), .stall(!adv), .den(den[s]), .num_in(num[s]),
			.rem_in(drem[s]), .quo_in(quo[s]),
			.rem_out(drem[s+1]), .quo_out(quo[s+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				den[s+1] <= den[s];
				sg[s+1] <= sg[s];
				wu[s+1] <= wu[s];
				num[s+1] <= num[s];
			end
		end
	end

	// Output: sign, saturate, or pass the input through when singular.
	localparam logic [NW-1:0] PosMax = NW'((1 << (CW - 1)) - 1);
	localparam logic [NW-1:0] NegMax = NW'(1) << (CW - 1);
	logic [CW-1:0] res [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sg[NDIV]) res[i] = raw[NST][i];
			else if (neg[NST][i])
				res[i] = -((quo[NDIV][i] > NegMax) ? CW'(NegMax) : CW'(quo[NDIV][i]));
			else res[i] = (quo[NDIV][i] > PosMax) ? CW'(PosMax) : CW'(quo[NDIV][i]);
		end
	end
	logic [CW-1:0] ux_q, uy_q, uz_q;
	logic st_q, wu_q, ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= v[NST];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ux_q <= res[0];
			uy_q <= res[1];
			uz_q <= res[2];
			st_q <= sg[NDIV];
			wu_q <= wu[NDIV];
		end
	end
	assign out_valid = ov_q;
	assign unit_x = ux_q;
	assign unit_y = uy_q;
	assign unit_z = uz_q;
	assign status = st_q;
	assign was_unit = wu_q;

	// A singular item never claims to be unit length.
	a_sing_not_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(status && was_unit)) else $error("singular item flagged unit");
	// A frozen pipe keeps the output item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(unit_x) && $stable(status))
		else $error("stalled output changed");
	// Input is refused only while the output is stalled.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("spurious input stall");
endmodule

>>> test/vector3_normalize_top_test.sv
`timescale 1ns / 1ps
module vector3_normalize_top_test;
	import v3n_pkg::*;

	localparam int CompWidth = 16;
	localparam int FracBits = 12;
	localparam int PipeLatency = 48;
	localparam int IdleLimit = 20000;

	typedef struct packed {
		logic signed [CompWidth-1:0] x;
		logic signed [CompWidth-1:0] y;
		logic signed [CompWidth-1:0] z;
		logic status;
		logic was_unit;
	} unit_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CompWidth-1:0] vec_x = '0;
	logic signed [CompWidth-1:0] vec_y = '0;
	logic signed [CompWidth-1:0] vec_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CompWidth-1:0] unit_x;
	logic signed [CompWidth-1:0] unit_y;
	logic signed [CompWidth-1:0] unit_z;
	logic status;
	logic was_unit;

	// Testbench copy of the two registers, used by the predictor.
	logic [RegWidth-1:0] singular_limit_q = SingularLimitReset;
	logic [RegWidth-1:0] unit_tolerance_q = UnitToleranceReset;

	unit_vec_t pending_units[$];
	int error_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int singular_count = 0;
	int unit_count = 0;
	int idle_cycles = 0;
	// Percent of cycles in which each side idles; zero gives a stretch with no idling.
	int send_idle_pct = 32;
	int recv_idle_pct = 32;
	bit hold_off = 1'b0;

	vector3_normalize_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.status(status), .was_unit(was_unit)
	);

	always #5 clk = ~clk;

	// Truncated square root by the bit-pair method.
	function automatic logic [31:0] sqrt_trunc(input logic [33:0] radicand);
		logic [33:0] rem;
		logic [33:0] root;
		logic [33:0] bit_w;
		rem = radicand;
		root = '0;
		bit_w = 34'd1 << 32;
		while (bit_w > rem) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem = rem - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root[31:0];
	endfunction

	// Divides one component by the norm, truncating toward zero and saturating.
	function automatic logic signed [CompWidth-1:0] scale_comp(
		input logic signed [CompWidth-1:0] comp, input logic [31:0] norm);
		logic [CompWidth:0] mag;
		logic [47:0] quot;
		mag = comp < 0 ? -$signed({comp[CompWidth-1], comp}) : {1'b0, comp};
		quot = ({31'd0, mag} << FracBits) / norm;
		if (comp < 0) begin
			if (quot > 48'd32768) quot = 48'd32768;
			return -$signed(quot[CompWidth-1:0]);
		end
		if (quot > 48'd32767) quot = 48'd32767;
		return quot[CompWidth-1:0];
	endfunction

	function automatic unit_vec_t normalize_vec(input logic signed [CompWidth-1:0] x,
		input logic signed [CompWidth-1:0] y, input logic signed [CompWidth-1:0] z);
		unit_vec_t res;
		logic [33:0] sum;
		logic [31:0] norm;
		logic [31:0] dev;
		sum = 34'($signed(x) * $signed(x)) + 34'($signed(y) * $signed(y))
			+ 34'($signed(z) * $signed(z));
		norm = sqrt_trunc(sum);
		if (norm <= singular_limit_q) begin
			res.x = x;
			res.y = y;
			res.z = z;
			res.status = 1'b1;
			res.was_unit = 1'b0;
			return res;
		end
		dev = norm >= (1 << FracBits) ? norm - (1 << FracBits) : (1 << FracBits) - norm;
		res.was_unit = dev <= unit_tolerance_q;
		res.status = 1'b0;
		res.x = scale_comp(x, norm);
		res.y = scale_comp(y, norm);
		res.z = scale_comp(z, norm);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch on result %0d: %s got %0d expected %0d",
			checked_count, what, got, want);
	endtask

	// The receiver stalls at random, or for a long hold-off when asked.
	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	// Checker: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		unit_vec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_units.size() == 0) begin
				error_count++;
				$display("result with no item outstanding");
			end else begin
				want = pending_units.pop_front();
				if (unit_x !== want.x) report_mismatch("unit_x", unit_x, want.x);
				if (unit_y !== want.y) report_mismatch("unit_y", unit_y, want.y);
				if (unit_z !== want.z) report_mismatch("unit_z", unit_z, want.z);
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (was_unit !== want.was_unit)
					report_mismatch("was_unit", was_unit, want.was_unit);
				if (want.status) singular_count++;
				if (want.was_unit) unit_count++;
			end
			checked_count++;
		end
	end

	// Watchdog on cycles in which neither channel accepts an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog expired with %0d results pending", pending_units.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Sends one item, idling at random first, and predicts its result on acceptance.
	// Valid stays high after acceptance so that the next item can follow at once.
	task automatic send_vec(input logic signed [CompWidth-1:0] x,
		input logic signed [CompWidth-1:0] y, input logic signed [CompWidth-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do @(posedge clk); while (in_stall);
		pending_units.push_back(normalize_vec(x, y, z));
		sent_count++;
	endtask

	// Waits for the pipe to drain, plus its latency, so a register write is safe.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_units.size() != 0) @(posedge clk);
		repeat (PipeLatency + 4) @(posedge clk);
	endtask

	// Writes a register in a setup and an access cycle, then reads it back.
	task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata[RegWidth-1:0] !== value[RegWidth-1:0])
			report_mismatch("register readback", prdata, value[RegWidth-1:0]);
		if (addr == AddrSingularLimit) singular_limit_q = value[RegWidth-1:0];
		else if (addr == AddrUnitTolerance) unit_tolerance_q = value[RegWidth-1:0];
	endtask

	function automatic logic signed [CompWidth-1:0] rand_comp();
		case ($urandom_range(3))
			0: return CompWidth'($urandom_range(8191) - 4096);
			1: return CompWidth'($urandom_range(255) - 128);
			default: return CompWidth'($urandom);
		endcase
	endfunction

	// Extremes, zero, exact unit vectors and near-singular vectors at reset settings.
	task automatic test_directed();
		send_vec(0, 0, 0);
		send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vec(-16'sh8000, -16'sh8000, -16'sh8000);
		send_vec(-16'sh8000, 0, 0);
		send_vec(0, 16'sh7fff, 0);
		send_vec(0, 0, -16'sh8000);
		send_vec(4096, 0, 0);
		send_vec(0, -4096, 0);
		send_vec(0, 0, 4099);
		send_vec(4101, 0, 0);
		send_vec(2365, 2365, 2365);
		send_vec(1, 0, 0);
		send_vec(1, 1, 0);
		send_vec(2, 0, 0);
		send_vec(-1, -1, -1);
		send_vec(16'sh5555, -16'sh2aab, 16'sh0f0f);
		send_vec(-3, 4, 0);
	endtask

	// Registers at their extremes: largest singular limit with no tolerance, then a zero limit, then full tolerance.
	task automatic test_register_extremes();
		drain_pipe();
		write_reg(AddrSingularLimit, 32'hffff_ffff);
		write_reg(AddrUnitTolerance, 32'd0);
		send_vec(16'sh7fff, -16'sh8000, 16'sh7fff);
		send_vec(4096, 0, 0);
		drain_pipe();
		write_reg(AddrSingularLimit, 32'd0);
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		send_vec(4096, 0, 0);
		send_vec(4097, 0, 0);
		drain_pipe();
		write_reg(AddrUnitTolerance, 32'h7fff);
		send_vec(-7, 3, 9);
		send_vec(16'sh7fff, 16'sh7fff, -16'sh8000);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
	endtask

	// Several random phases, each with its own register setting.
	task automatic test_random_settings();
		for (int phase = 0; phase < 4; phase++) begin
			drain_pipe();
			write_reg(AddrSingularLimit, $urandom_range(phase * 700));
			write_reg(AddrUnitTolerance, $urandom_range(phase * 40));
			test_random(395);
		end
	endtask

	// No idling on either side, so items flow at full rate.
	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(200);
		send_idle_pct = 32;
		recv_idle_pct = 32;
	endtask

	// The receiver holds off long enough for the pipe to fill and stall the input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(150);
		join
		send_idle_pct = 32;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_full_rate();
		test_backpressure();
		drain_pipe();
		$display("%0d vectors sent, %0d results checked (%0d singular, %0d unit)",
			sent_count, checked_count, singular_count, unit_count);
		$display("covered register extremes, random settings, full rate and back-pressure");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
